>>> src/rwss_pkg.sv
// ----------------------------------------------------------------------------
// rwss_pkg
// Shared constants, codes and control types of the read/write starvation
// scheduler.
// ----------------------------------------------------------------------------
package rwss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TAG_BITS    = 8;
  localparam int TAG_PORT_W  = 8;

  localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;

  localparam int LIMIT_W   = 8;
  localparam int STARVE_W  = 9;
  localparam int STARVE_MAX = 511;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(8);
  localparam logic [LIMIT_W-1:0] LIMIT_OFF_RESET = LIMIT_W'(0);

  localparam logic [2:0] CMD_ENQUEUE   = 3'd0;
  localparam logic [2:0] CMD_DISPATCH  = 3'd1;
  localparam logic [2:0] CMD_REMOVE    = 3'd2;
  localparam logic [2:0] CMD_QPREV     = 3'd3;
  localparam logic [2:0] CMD_QNEXT     = 3'd4;
  localparam logic [2:0] CMD_SCREEN    = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  localparam logic REG_LIMIT     = 1'b0;
  localparam logic REG_LIMIT_OFF = 1'b1;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_NEXT,
    RD_PREV
  } rd_sel_e;

  typedef struct packed {
    logic       load;
    logic       disp_pick;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       wr_enq;
    logic       wr_shift;
    logic       idx_inc;
    logic       cnt_dec;
    logic       cap_res;
    logic       cap_head;
    logic       screen_set;
    logic       fin;
    logic [1:0] fin_status;
  } dp_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic disp_none;
    logic match;
    logic last;
    logic first;
  } dp_stat_t;

endpackage

>>> src/rwss_ram.sv
// ----------------------------------------------------------------------------
// rwss_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rwss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/rwss_datapath.sv
// ----------------------------------------------------------------------------
// rwss_datapath
// Queue storage, fill counts, starvation counter, screen state and the
// result registers of the scheduler.
// ----------------------------------------------------------------------------
module rwss_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              direction_i,
  input  logic [7:0]                        request_tag_i,
  input  logic                              screen_on_i,
  input  logic [rwss_pkg::LIMIT_W-1:0]      limit_i,
  input  logic [rwss_pkg::LIMIT_W-1:0]      limit_off_i,
  input  rwss_pkg::dp_ctrl_t                ctrl_i,
  output rwss_pkg::dp_stat_t                stat_o,
  output logic                              valid_o,
  output logic [1:0]                        status_o,
  output logic [rwss_pkg::TAG_PORT_W-1:0]   result_tag_o,
  output logic                              result_direction_o
);

  logic [rwss_pkg::TAG_BITS-1:0] tag_q;
  logic                          dir_q;
  logic                          scr_q;
  logic [rwss_pkg::IDX_W-1:0]    idx_q;
  logic [rwss_pkg::TAG_BITS-1:0] res_tag_q;
  logic                          res_dir_q;

  logic [rwss_pkg::CNT_W-1:0]    rcnt_q, rcnt_d;
  logic [rwss_pkg::CNT_W-1:0]    wcnt_q, wcnt_d;
  logic [rwss_pkg::STARVE_W-1:0] starve_q, starve_d;
  logic                          screen_q, screen_d;
  logic                          valid_q;
  logic [1:0]                    status_q;

  logic [rwss_pkg::CNT_W-1:0]    cnt_sel;
  logic [rwss_pkg::LIMIT_W-1:0]  limit_sel;
  logic                          starved;
  logic                          disp_read;

  logic                          ram_we;
  logic [rwss_pkg::ADDR_W-1:0]   ram_waddr;
  logic [rwss_pkg::TAG_BITS-1:0] ram_wdata;
  logic [rwss_pkg::IDX_W-1:0]    rd_idx;
  logic [rwss_pkg::TAG_BITS-1:0] ram_rdata;

  always_comb begin
    cnt_sel   = dir_q ? wcnt_q : rcnt_q;
    limit_sel = screen_q ? limit_i : limit_off_i;
    starved   = starve_q > rwss_pkg::STARVE_W'(limit_sel);
    disp_read = !starved && (rcnt_q != '0);
  end

  always_comb begin
    stat_o.full      = cnt_sel >= rwss_pkg::CNT_W'(rwss_pkg::QUEUE_DEPTH);
    stat_o.empty     = cnt_sel == '0;
    stat_o.disp_none = !disp_read && (wcnt_q == '0);
    stat_o.match     = ram_rdata == tag_q;
    stat_o.last      = (rwss_pkg::CNT_W'(idx_q) + rwss_pkg::CNT_W'(1)) >= cnt_sel;
    stat_o.first     = idx_q == '0;
  end

  // Both queues share one memory; the direction picks the upper or lower half.
  always_comb begin
    unique case (ctrl_i.rd_sel)
      rwss_pkg::RD_NEXT: rd_idx = idx_q + rwss_pkg::IDX_W'(1);
      rwss_pkg::RD_PREV: rd_idx = idx_q - rwss_pkg::IDX_W'(1);
      default:           rd_idx = idx_q;
    endcase
  end

  always_comb begin
    ram_we    = ctrl_i.wr_enq || ctrl_i.wr_shift;
    ram_waddr = ctrl_i.wr_enq ? {dir_q, cnt_sel[rwss_pkg::IDX_W-1:0]} : {dir_q, idx_q};
    ram_wdata = ctrl_i.wr_enq ? tag_q : ram_rdata;
  end

  rwss_ram #(
    .WIDTH (rwss_pkg::TAG_BITS),
    .DEPTH (2 ** rwss_pkg::ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ctrl_i.rd_en),
    .raddr_i ({dir_q, rd_idx}),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    rcnt_d   = rcnt_q;
    wcnt_d   = wcnt_q;
    starve_d = starve_q;
    screen_d = screen_q;
    if (ctrl_i.wr_enq) begin
      if (dir_q) begin
        wcnt_d = wcnt_q + rwss_pkg::CNT_W'(1);
      end else begin
        rcnt_d = rcnt_q + rwss_pkg::CNT_W'(1);
      end
    end
    if (ctrl_i.cnt_dec) begin
      if (dir_q) begin
        wcnt_d = wcnt_q - rwss_pkg::CNT_W'(1);
      end else begin
        rcnt_d = rcnt_q - rwss_pkg::CNT_W'(1);
      end
    end
    if (ctrl_i.disp_pick) begin
      if (disp_read) begin
        if (starve_q < rwss_pkg::STARVE_W'(rwss_pkg::STARVE_MAX)) begin
          starve_d = starve_q + rwss_pkg::STARVE_W'(1);
        end
      end else begin
        starve_d = '0;
      end
    end
    if (ctrl_i.screen_set) begin
      screen_d = scr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rcnt_q   <= '0;
      wcnt_q   <= '0;
      starve_q <= '0;
      screen_q <= 1'b1;
      valid_q  <= 1'b0;
      status_q <= rwss_pkg::ST_OK;
    end else begin
      rcnt_q   <= rcnt_d;
      wcnt_q   <= wcnt_d;
      starve_q <= starve_d;
      screen_q <= screen_d;
      valid_q  <= ctrl_i.fin;
      if (ctrl_i.fin) begin
        status_q <= ctrl_i.fin_status;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      tag_q     <= rwss_pkg::TAG_BITS'(request_tag_i);
      dir_q     <= direction_i;
      scr_q     <= screen_on_i;
      idx_q     <= '0;
      res_tag_q <= '0;
      res_dir_q <= 1'b0;
    end else begin
      if (ctrl_i.disp_pick) begin
        dir_q <= !disp_read;
      end
      if (ctrl_i.idx_inc) begin
        idx_q <= idx_q + rwss_pkg::IDX_W'(1);
      end
      if (ctrl_i.cap_res) begin
        res_tag_q <= ram_rdata;
      end
      if (ctrl_i.cap_head) begin
        res_tag_q <= ram_rdata;
        res_dir_q <= dir_q;
      end
    end
  end

  assign valid_o            = valid_q;
  assign status_o           = status_q;
  assign result_tag_o       = rwss_pkg::TAG_PORT_W'(res_tag_q);
  assign result_direction_o = res_dir_q;

endmodule

>>> src/rwss_ctrl.sv
// ----------------------------------------------------------------------------
// rwss_ctrl
// Command sequencer: decodes a command and steps the datapath through the
// queue search, head read and shift-down sequences.
// ----------------------------------------------------------------------------
module rwss_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic [2:0]         command_i,
  input  rwss_pkg::dp_stat_t stat_i,
  output rwss_pkg::dp_ctrl_t ctrl_o,
  output logic               busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_HEAD_RD   = 4'd2;
  localparam logic [3:0] S_HEAD_CAP  = 4'd3;
  localparam logic [3:0] S_SRCH_RD   = 4'd4;
  localparam logic [3:0] S_SRCH_CMP  = 4'd5;
  localparam logic [3:0] S_Q_CAP     = 4'd6;
  localparam logic [3:0] S_SHIFT_CHK = 4'd7;
  localparam logic [3:0] S_SHIFT_WR  = 4'd8;

  logic [3:0] state_q, state_d;
  logic [2:0] cmd_q;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cmd_q) inside
          rwss_pkg::CMD_ENQUEUE: begin
            ctrl_o.fin = 1'b1;
            state_d    = S_IDLE;
            if (stat_i.full) begin
              ctrl_o.fin_status = rwss_pkg::ST_FULL;
            end else begin
              ctrl_o.wr_enq     = 1'b1;
              ctrl_o.fin_status = rwss_pkg::ST_OK;
            end
          end
          rwss_pkg::CMD_DISPATCH: begin
            ctrl_o.disp_pick = 1'b1;
            if (stat_i.disp_none) begin
              ctrl_o.fin        = 1'b1;
              ctrl_o.fin_status = rwss_pkg::ST_NONE;
              state_d           = S_IDLE;
            end else begin
              state_d = S_HEAD_RD;
            end
          end
          rwss_pkg::CMD_REMOVE, rwss_pkg::CMD_QPREV, rwss_pkg::CMD_QNEXT: begin
            if (stat_i.empty) begin
              ctrl_o.fin        = 1'b1;
              ctrl_o.fin_status = rwss_pkg::ST_MISSING;
              state_d           = S_IDLE;
            end else begin
              state_d = S_SRCH_RD;
            end
          end
          rwss_pkg::CMD_SCREEN: begin
            ctrl_o.screen_set = 1'b1;
            ctrl_o.fin        = 1'b1;
            ctrl_o.fin_status = rwss_pkg::ST_OK;
            state_d           = S_IDLE;
          end
          default: begin
            ctrl_o.fin        = 1'b1;
            ctrl_o.fin_status = rwss_pkg::ST_NONE;
            state_d           = S_IDLE;
          end
        endcase
      end
      S_HEAD_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = rwss_pkg::RD_IDX;
        state_d       = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        ctrl_o.cap_head = 1'b1;
        state_d         = S_SHIFT_CHK;
      end
      S_SRCH_RD: begin
        ctrl_o.rd_en  = 1'b1;
        ctrl_o.rd_sel = rwss_pkg::RD_IDX;
        state_d       = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat_i.match) begin
          if (cmd_q == rwss_pkg::CMD_REMOVE) begin
            state_d = S_SHIFT_CHK;
          end else if (cmd_q == rwss_pkg::CMD_QPREV) begin
            if (stat_i.first) begin
              ctrl_o.fin        = 1'b1;
              ctrl_o.fin_status = rwss_pkg::ST_NONE;
              state_d           = S_IDLE;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = rwss_pkg::RD_PREV;
              state_d       = S_Q_CAP;
            end
          end else begin
            if (stat_i.last) begin
              ctrl_o.fin        = 1'b1;
              ctrl_o.fin_status = rwss_pkg::ST_NONE;
              state_d           = S_IDLE;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = rwss_pkg::RD_NEXT;
              state_d       = S_Q_CAP;
            end
          end
        end else if (stat_i.last) begin
          ctrl_o.fin        = 1'b1;
          ctrl_o.fin_status = rwss_pkg::ST_MISSING;
          state_d           = S_IDLE;
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = S_SRCH_RD;
        end
      end
      S_Q_CAP: begin
        ctrl_o.cap_res    = 1'b1;
        ctrl_o.fin        = 1'b1;
        ctrl_o.fin_status = rwss_pkg::ST_OK;
        state_d           = S_IDLE;
      end
      // Close the gap at the current position by moving each later entry
      // down one place, then shorten the queue.
      S_SHIFT_CHK: begin
        if (stat_i.last) begin
          ctrl_o.cnt_dec    = 1'b1;
          ctrl_o.fin        = 1'b1;
          ctrl_o.fin_status = rwss_pkg::ST_OK;
          state_d           = S_IDLE;
        end else begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = rwss_pkg::RD_NEXT;
          state_d       = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        ctrl_o.wr_shift = 1'b1;
        ctrl_o.idx_inc  = 1'b1;
        state_d         = S_SHIFT_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= rwss_pkg::CMD_ENQUEUE;
    end else begin
      state_q <= state_d;
      if (ctrl_o.load) begin
        cmd_q <= command_i;
      end
    end
  end

  assign busy = state_q != S_IDLE;

endmodule

>>> src/read_write_starvation_scheduler.sv
// ----------------------------------------------------------------------------
// read_write_starvation_scheduler
// Read-priority request scheduler with a write starvation limit.
// ----------------------------------------------------------------------------
// A command is taken when start is high while busy is low, and exactly one
// result word follows, marked by valid_o for a single cycle; the receiver
// cannot stall it, so it must take every word as it appears. Enqueue, set
// screen and unknown commands finish in the decode state and show their
// result in the cycle after it. All queue contents sit in one single-port
// read, single-port write RAM with a registered read, so remove and the
// neighbour queries walk the queue one entry at a time, reading and then
// comparing each entry searched, and remove and dispatch close the gap by
// reading and then writing back each entry behind it. The screen-on limit
// is register 0 (byte address 0), the screen-off limit is register 1 (byte
// address 4); write them only while busy is low.
// ----------------------------------------------------------------------------
module read_write_starvation_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic        direction_i,
  input  logic [7:0]  request_tag_i,
  input  logic        screen_on_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic [7:0]  result_tag_o,
  output logic        result_direction_o
);

  logic [rwss_pkg::LIMIT_W-1:0] limit_q;
  logic [rwss_pkg::LIMIT_W-1:0] limit_off_q;
  logic                         cfg_wr;

  rwss_pkg::dp_ctrl_t ctrl;
  rwss_pkg::dp_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= rwss_pkg::LIMIT_RESET;
      limit_off_q <= rwss_pkg::LIMIT_OFF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        rwss_pkg::REG_LIMIT:     limit_q     <= pwdata[rwss_pkg::LIMIT_W-1:0];
        rwss_pkg::REG_LIMIT_OFF: limit_off_q <= pwdata[rwss_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rwss_pkg::REG_LIMIT_OFF: prdata = 32'(limit_off_q);
      default:                 prdata = 32'(limit_q);
    endcase
  end

  rwss_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .stat_i    (stat),
    .ctrl_o    (ctrl),
    .busy      (busy)
  );

  rwss_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .direction_i        (direction_i),
    .request_tag_i      (request_tag_i),
    .screen_on_i        (screen_on_i),
    .limit_i            (limit_q),
    .limit_off_i        (limit_off_q),
    .ctrl_i             (ctrl),
    .stat_o             (stat),
    .valid_o            (valid_o),
    .status_o           (status_o),
    .result_tag_o       (result_tag_o),
    .result_direction_o (result_direction_o)
  );

endmodule
